### src/foot_torque_orientation_controller_assert.svh
// Assertion macros for the foot torque orientation controller checker.
// Used by the checker file only; depends on nothing else.
`ifndef FOOT_TORQUE_ORIENTATION_CONTROLLER_ASSERT_SVH
`define FOOT_TORQUE_ORIENTATION_CONTROLLER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define FTOC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define FTOC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/ftoc_pkg.sv
// Shared types and constants of the foot torque orientation controller.
// No dependencies; used by every RTL module of the block.
`timescale 1ns / 1ps

package ftoc_pkg;

   localparam int TORQUE_W = 32;
   localparam int ERR_W    = TORQUE_W + 1;
   localparam int ANGLE_W  = 17;
   localparam int ANGLE_X_W = 15;
   localparam int DT_W     = 24;

   // Clamp bounds in Q16.16 (0.2, 0.7, 0.5 truncated)
   localparam logic signed [ANGLE_W-1:0] X_LO = -17'sd13107;
   localparam logic signed [ANGLE_W-1:0] X_HI =  17'sd13107;
   localparam logic signed [ANGLE_W-1:0] Y_LO = -17'sd45875;
   localparam logic signed [ANGLE_W-1:0] Y_HI =  17'sd32768;

   // Error change saturates to +/-(2^32 - 1)
   localparam logic signed [ERR_W:0] DE_HI =  34'sh0_FFFF_FFFF;
   localparam logic signed [ERR_W:0] DE_LO = -34'sh0_FFFF_FFFF;

   // Rate term saturates to a 40-bit signed range
   localparam logic signed [49:0] RATE_HI =  50'sd549755813887;
   localparam logic signed [49:0] RATE_LO = -50'sd549755813888;

   localparam logic [DT_W-1:0] TIME_STEP_RESET = 24'd83886;

   typedef enum logic [1:0] {
      CSR_PROP_GAIN,
      CSR_DERIV_GAIN,
      CSR_LEAK_GAIN,
      CSR_TIME_STEP
   } ftoc_csr_type;

   // Step commands from the controller to the datapath
   typedef struct packed {
      logic capture;
      logic mul1;
      logic mul2;
      logic mul3;
      logic finish;
   } ftoc_cmd_type;

endpackage

### src/foot_torque_orientation_controller.sv
// Foot torque orientation controller: leaky PD ankle admittance law.
//
// Usage:
//   req_* carries one control tick for one foot: desired and measured ankle
//   torque about x and y (Q16.16) in tdata, the foot select in tuser.
//   rsp_* returns that foot's updated, clamped orientation correction.
//   csr_* writes the gains and the time step; write only while idle.
// Sequence: an accepted transfer passes three multiply steps, then sum,
//   clamp and write-back, before its result shows on rsp_tvalid.
// Overlap: the next item is taken in the cycle that finishes the current
//   one, so a new item waits until the last one is through; each axis has
//   two multipliers that each run two products in sequence.
// Reset: both feet's errors and corrections clear to zero, gains clear to
//   zero and the time step returns to 5 ms.
// Stall: a result held on rsp_* stays until taken; the next item still goes
//   through its multiply steps and waits at the final step for the slot.
`timescale 1ns / 1ps

module foot_torque_orientation_controller (
   input  logic         clock,
   input  logic         reset,
   // input channel
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,  // desired_torque_x, desired_torque_y,
                                    // measured_torque_x, measured_torque_y
   input  logic         req_tuser,  // right_foot
   // result channel
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [31:0]  rsp_tdata,  // angle_x [14:0], angle_y [31:15]
   // control register writes
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [31:0]  csr_wdata
);

   ftoc_pkg::ftoc_cmd_type cmd;

   // sequence the steps of one tick and own the handshakes
   ftoc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   // compute both axes and hold the result for transfer
   ftoc_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tdata (rsp_tdata),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

endmodule

### src/ftoc_ctrl.sv
// Sequencer of the foot torque orientation controller.
// Depends on ftoc_pkg for the command struct.
`timescale 1ns / 1ps

module ftoc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output ftoc_pkg::ftoc_cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL1,
      ST_MUL2,
      ST_MUL3,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      finish_go;
   logic      accept;

   // output slot is free or is being emptied this cycle
   assign finish_go  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) || ((state_ff == ST_FINISH) && finish_go);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;

   assign cmd.capture = accept;
   assign cmd.mul1    = (state_ff == ST_MUL1);
   assign cmd.mul2    = (state_ff == ST_MUL2);
   assign cmd.mul3    = (state_ff == ST_MUL3);
   assign cmd.finish  = (state_ff == ST_FINISH) && finish_go;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_MUL1;
            end
         end
         ST_MUL1: state_in = ST_MUL2;
         ST_MUL2: state_in = ST_MUL3;
         ST_MUL3: state_in = ST_FINISH;
         ST_FINISH: begin
            if (finish_go) begin
               rsp_valid_in = 1'b1;
               state_in     = accept ? ST_MUL1 : ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### src/ftoc_axis.sv
// One axis of the leaky PD update, with per-foot error and correction state.
// Depends on ftoc_pkg for widths, saturation bounds and the command struct.
`timescale 1ns / 1ps

module ftoc_axis (
   input  logic                                   clock,
   input  logic                                   reset,
   input  ftoc_pkg::ftoc_cmd_type                 cmd,
   input  logic                                   foot_sel,
   input  logic signed [ftoc_pkg::TORQUE_W-1:0]   desired,
   input  logic signed [ftoc_pkg::TORQUE_W-1:0]   measured,
   input  logic signed [ftoc_pkg::TORQUE_W-1:0]   prop_gain,
   input  logic signed [ftoc_pkg::TORQUE_W-1:0]   deriv_gain,
   input  logic signed [ftoc_pkg::TORQUE_W-1:0]   leak_gain,
   input  logic        [ftoc_pkg::DT_W-1:0]       time_step,
   input  logic signed [ftoc_pkg::ANGLE_W-1:0]    lo_bound,
   input  logic signed [ftoc_pkg::ANGLE_W-1:0]    hi_bound,
   output logic signed [ftoc_pkg::ANGLE_W-1:0]    angle_new
);

   logic signed [ftoc_pkg::ERR_W-1:0]   err_ff;
   logic signed [ftoc_pkg::ERR_W-1:0]   prev_err_ff [2];
   logic signed [ftoc_pkg::ANGLE_W-1:0] corr_ff [2];
   logic signed [ftoc_pkg::ANGLE_W-1:0] u_ff;
   logic signed [ftoc_pkg::ERR_W-1:0]   de_ff;
   logic signed [48:0]                  p_ff;
   logic signed [32:0]                  l_ff;
   logic signed [48:0]                  d_ff;
   logic signed [39:0]                  rate_ff;
   logic signed [39:0]                  t_ff;

   logic signed [ftoc_pkg::ERR_W-1:0]   err_in;
   logic signed [ftoc_pkg::ERR_W:0]     de_raw;
   logic signed [ftoc_pkg::ERR_W-1:0]   de_sat;
   logic signed [31:0]                  mul_a_x;
   logic signed [32:0]                  mul_a_y;
   logic signed [64:0]                  prod_a;
   logic signed [39:0]                  mul_b_x;
   logic signed [24:0]                  mul_b_y;
   logic signed [64:0]                  prod_b;
   logic signed [49:0]                  rate_raw;
   logic signed [39:0]                  rate_sat;
   logic signed [50:0]                  sum;

   assign err_in = 33'(desired) - 33'(measured);

   // error change, saturated
   assign de_raw = 34'(err_ff) - 34'(prev_err_ff[foot_sel]);
   always_comb begin
      priority if (de_raw > ftoc_pkg::DE_HI) begin
         de_sat = ftoc_pkg::DE_HI[32:0];
      end else if (de_raw < ftoc_pkg::DE_LO) begin
         de_sat = ftoc_pkg::DE_LO[32:0];
      end else begin
         de_sat = de_raw[32:0];
      end
   end

   // gain multiplier: prop gain on error, then deriv gain on error change
   assign mul_a_x = cmd.mul1 ? prop_gain : deriv_gain;
   assign mul_a_y = cmd.mul1 ? err_ff : de_ff;
   assign prod_a  = mul_a_x * mul_a_y;

   // second multiplier: leak gain on correction, then rate on time step
   assign mul_b_x = cmd.mul1 ? 40'(leak_gain) : rate_ff;
   assign mul_b_y = cmd.mul1 ? 25'(corr_ff[foot_sel]) : $signed({1'b0, time_step});
   assign prod_b  = mul_b_x * mul_b_y;

   assign rate_raw = 50'(p_ff) - 50'(l_ff);
   always_comb begin
      priority if (rate_raw > ftoc_pkg::RATE_HI) begin
         rate_sat = ftoc_pkg::RATE_HI[39:0];
      end else if (rate_raw < ftoc_pkg::RATE_LO) begin
         rate_sat = ftoc_pkg::RATE_LO[39:0];
      end else begin
         rate_sat = rate_raw[39:0];
      end
   end

   assign sum = 51'(u_ff) + 51'(t_ff) + 51'(d_ff);
   always_comb begin
      priority if (sum < 51'(lo_bound)) begin
         angle_new = lo_bound;
      end else if (sum > 51'(hi_bound)) begin
         angle_new = hi_bound;
      end else begin
         angle_new = sum[ftoc_pkg::ANGLE_W-1:0];
      end
   end

   // products are floored by taking the upper bits
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         err_ff <= err_in;
      end
      if (cmd.mul1) begin
         p_ff  <= prod_a[64:16];
         l_ff  <= prod_b[48:16];
         de_ff <= de_sat;
         u_ff  <= corr_ff[foot_sel];
      end
      if (cmd.mul2) begin
         d_ff    <= prod_a[64:16];
         rate_ff <= rate_sat;
      end
      if (cmd.mul3) begin
         t_ff <= prod_b[63:24];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 2; i++) begin
            prev_err_ff[i] <= '0;
            corr_ff[i]     <= '0;
         end
      end else if (cmd.finish) begin
         prev_err_ff[foot_sel] <= err_ff;
         corr_ff[foot_sel]     <= angle_new;
      end
   end

endmodule

### src/ftoc_datapath.sv
// Datapath: control registers, foot select, two axis lanes, result register.
// Depends on ftoc_pkg and ftoc_axis.
`timescale 1ns / 1ps

module ftoc_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  ftoc_pkg::ftoc_cmd_type cmd,
   input  logic [127:0]           req_tdata,
   input  logic                   req_tuser,
   output logic [31:0]            rsp_tdata,
   input  logic                   csr_we,
   input  logic [1:0]             csr_index,
   input  logic [31:0]            csr_wdata
);

   logic signed [31:0]                  prop_gain_ff;
   logic signed [31:0]                  deriv_gain_ff;
   logic signed [31:0]                  leak_gain_ff;
   logic        [ftoc_pkg::DT_W-1:0]    time_step_ff;
   logic                                foot_ff;
   logic        [31:0]                  rsp_data_ff;
   logic signed [ftoc_pkg::ANGLE_W-1:0] angle_x_new;
   logic signed [ftoc_pkg::ANGLE_W-1:0] angle_y_new;

   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff  <= '0;
         deriv_gain_ff <= '0;
         leak_gain_ff  <= '0;
         time_step_ff  <= ftoc_pkg::TIME_STEP_RESET;
      end else if (csr_we) begin
         unique case (ftoc_pkg::ftoc_csr_type'(csr_index))
            ftoc_pkg::CSR_PROP_GAIN:  prop_gain_ff  <= csr_wdata;
            ftoc_pkg::CSR_DERIV_GAIN: deriv_gain_ff <= csr_wdata;
            ftoc_pkg::CSR_LEAK_GAIN:  leak_gain_ff  <= csr_wdata;
            ftoc_pkg::CSR_TIME_STEP:  time_step_ff  <= csr_wdata[ftoc_pkg::DT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         foot_ff <= req_tuser;
      end
      if (cmd.finish) begin
         rsp_data_ff <= {angle_y_new, angle_x_new[ftoc_pkg::ANGLE_X_W-1:0]};
      end
   end

   assign rsp_tdata = rsp_data_ff;

   ftoc_axis u_axis_x (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .foot_sel   (foot_ff),
      .desired    (req_tdata[31:0]),
      .measured   (req_tdata[95:64]),
      .prop_gain  (prop_gain_ff),
      .deriv_gain (deriv_gain_ff),
      .leak_gain  (leak_gain_ff),
      .time_step  (time_step_ff),
      .lo_bound   (ftoc_pkg::X_LO),
      .hi_bound   (ftoc_pkg::X_HI),
      .angle_new  (angle_x_new)
   );

   ftoc_axis u_axis_y (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .foot_sel   (foot_ff),
      .desired    (req_tdata[63:32]),
      .measured   (req_tdata[127:96]),
      .prop_gain  (prop_gain_ff),
      .deriv_gain (deriv_gain_ff),
      .leak_gain  (leak_gain_ff),
      .time_step  (time_step_ff),
      .lo_bound   (ftoc_pkg::Y_LO),
      .hi_bound   (ftoc_pkg::Y_HI),
      .angle_new  (angle_y_new)
   );

endmodule

### src/ftoc_checker.sv
// Port-level checker for the foot torque orientation controller, and its bind.
// Depends on foot_torque_orientation_controller_assert.svh.
`timescale 1ns / 1ps
`include "foot_torque_orientation_controller_assert.svh"

module ftoc_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [31:0]  rsp_tdata
);

   logic in_xfer;
   logic stalled;
   logic range_ok;

   assign in_xfer  = req_tvalid && req_tready;
   assign stalled  = rsp_tvalid && !rsp_tready;
   assign range_ok = ($signed(rsp_tdata[14:0]) >= -15'sd13107)
                  && ($signed(rsp_tdata[14:0]) <= 15'sd13107)
                  && ($signed(rsp_tdata[31:15]) >= -17'sd45875)
                  && ($signed(rsp_tdata[31:15]) <= 17'sd32768);

   // hold a stalled result
   `FTOC_ASSERT_NEXT(a_rsp_hold, clock, reset, stalled, rsp_tvalid, "result dropped while stalled")
   // busy right after taking an item
   `FTOC_ASSERT_NEXT(a_busy_after_take, clock, reset, in_xfer, !req_tready, "input taken back to back")
   // corrections stay inside the clamp range
   `FTOC_ASSERT_SAME(a_angle_range, clock, reset, rsp_tvalid, range_ok, "angle out of range")
   // a fresh result follows a busy multiply step
   `FTOC_ASSERT_SAME(a_rise_after_busy, clock, reset, $rose(rsp_tvalid), $past(!req_tready, 2), "result too early")

endmodule

bind foot_torque_orientation_controller ftoc_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

### tb/foot_torque_orientation_controller_tb.sv
// Self-checking testbench for the foot torque orientation controller.
// Predicts each foot's clamped correction from the leaky PD law in
// 64-bit arithmetic; depends on ftoc_pkg and the controller RTL.
`timescale 1ns / 1ps

module foot_torque_orientation_controller_tb;

   localparam int UNITY = 65536;  // 1.0 in Q16.16

   // expected angles for one transfer, packed as on rsp_tdata
   typedef struct packed {
      logic [16:0] angle_y;
      logic [14:0] angle_x;
   } angle_pair_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [127:0] req_tdata;   // desired_torque_x, desired_torque_y,
                              // measured_torque_x, measured_torque_y
   logic         req_tuser;   // right_foot
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [31:0]  rsp_tdata;   // angle_x, angle_y
   logic         csr_we;
   logic [1:0]   csr_index;
   logic [31:0]  csr_wdata;

   foot_torque_orientation_controller uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // Predictor state: gains, time step and per-foot error and correction.
   longint kp_gain = 0;
   longint kd_gain = 0;
   longint kl_gain = 0;
   longint dt_step = 83886;
   longint last_err_x[2] = '{0, 0};
   longint last_err_y[2] = '{0, 0};
   longint corr_x[2] = '{0, 0};
   longint corr_y[2] = '{0, 0};

   angle_pair_type pending_angles[$];
   int             mismatch_count = 0;

   // Flow control shared by the sender and the receiver.
   bit steady_flow = 1'b0;     // suppress random idling on both sides
   int stall_request = 0;      // cycles of hold-off asked of the receiver
   int hold_left = 0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Watchdog: even the slowest legal run ends far sooner than this.
   initial begin
      #5_000_000;
      $display("foot_torque_orientation_controller: mismatch");
      $finish;
   end

   function automatic longint clip(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   // One axis of the leaky PD update. Every product is floored back to
   // Q16.16 by an arithmetic shift; the rate and the error change saturate
   // before they are used, the sum is exact and then clamped.
   function automatic longint next_angle(longint u, longint e, longint e_last,
                                         longint lo, longint hi);
      longint p, l, rate, dt_term, de, d;
      p = (kp_gain * e) >>> 16;
      l = (kl_gain * u) >>> 16;
      rate = clip(p - l, longint'(ftoc_pkg::RATE_LO), longint'(ftoc_pkg::RATE_HI));
      dt_term = (rate * dt_step) >>> 24;
      de = clip(e - e_last, longint'(ftoc_pkg::DE_LO), longint'(ftoc_pkg::DE_HI));
      d = (kd_gain * de) >>> 16;
      return clip(u + dt_term + d, lo, hi);
   endfunction

   // Advance the selected foot and queue the angles it must report.
   task automatic predict_tick(input logic foot, input logic [31:0] dx, dy,
                               input logic [31:0] mx, my);
      longint ex, ey;
      int f;
      angle_pair_type want;
      f = foot ? 1 : 0;
      ex = longint'($signed(dx)) - longint'($signed(mx));
      ey = longint'($signed(dy)) - longint'($signed(my));
      corr_x[f] = next_angle(corr_x[f], ex, last_err_x[f],
                             longint'(ftoc_pkg::X_LO), longint'(ftoc_pkg::X_HI));
      corr_y[f] = next_angle(corr_y[f], ey, last_err_y[f],
                             longint'(ftoc_pkg::Y_LO), longint'(ftoc_pkg::Y_HI));
      last_err_x[f] = ex;
      last_err_y[f] = ey;
      want.angle_x = corr_x[f][14:0];
      want.angle_y = corr_y[f][16:0];
      pending_angles.push_back(want);
   endtask

   // Offer one control tick; keep tvalid high from one tick to the next
   // unless a random idle cycle falls between them.
   task automatic send_tick(input logic foot, input logic [31:0] dx, dy,
                            input logic [31:0] mx, my);
      @(negedge clock);
      if (!steady_flow) begin
         while ($urandom_range(0, 99) < 11) begin
            req_tvalid <= 1'b0;
            @(negedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tuser  <= foot;
      req_tdata  <= {my, mx, dy, dx};
      do @(posedge clock); while (!req_tready);
      predict_tick(foot, dx, dy, mx, my);
   endtask

   // Drop tvalid, let every queued result drain, then allow for the
   // pipeline depth before anything touches the registers.
   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_angles.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input ftoc_pkg::ftoc_csr_type idx, input logic [31:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we    <= 1'b0;
      case (idx)
         ftoc_pkg::CSR_PROP_GAIN:  kp_gain = longint'($signed(val));
         ftoc_pkg::CSR_DERIV_GAIN: kd_gain = longint'($signed(val));
         ftoc_pkg::CSR_LEAK_GAIN:  kl_gain = longint'($signed(val));
         ftoc_pkg::CSR_TIME_STEP:  dt_step = longint'(val[23:0]);
         default: ;
      endcase
   endtask

   task automatic set_gains(input logic [31:0] kp, kd, kl, input logic [23:0] dt);
      wait_drained();
      write_reg(ftoc_pkg::CSR_PROP_GAIN, kp);
      write_reg(ftoc_pkg::CSR_DERIV_GAIN, kd);
      write_reg(ftoc_pkg::CSR_LEAK_GAIN, kl);
      write_reg(ftoc_pkg::CSR_TIME_STEP, {8'h00, dt});
   endtask

   // Mostly torques within a few Nm so the correction moves inside its
   // limits; now and then any 32-bit value.
   function automatic logic [31:0] pick_torque();
      if ($urandom_range(0, 99) < 15) return $urandom;
      return $urandom_range(0, 393216) - 196608;
   endfunction

   task automatic run_random_ticks(input int count);
      logic [31:0] dx, dy;
      repeat (count) begin
         dx = pick_torque();
         dy = pick_torque();
         // often measure close to the demand so the error stays small
         if ($urandom_range(0, 99) < 40)
            send_tick(1'($urandom_range(0, 1)), dx, dy,
                      dx + $urandom_range(0, 8192) - 4096,
                      dy + $urandom_range(0, 8192) - 4096);
         else
            send_tick(1'($urandom_range(0, 1)), dx, dy, pick_torque(), pick_torque());
      end
   endtask

   // Check every result transfer against the oldest prediction.
   task automatic flag_mismatch(input string what, input longint want, got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t: %s expected %0d, got %0d", $realtime, what, want, got);
   endtask

   always @(posedge clock) begin
      angle_pair_type want, got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (pending_angles.size() == 0) begin
            flag_mismatch("unexpected result, angle_x", longint'(0),
                          longint'($signed(got.angle_x)));
         end else begin
            want = pending_angles.pop_front();
            if (got.angle_x !== want.angle_x)
               flag_mismatch("angle_x", longint'($signed(want.angle_x)),
                             longint'($signed(got.angle_x)));
            if (got.angle_y !== want.angle_y)
               flag_mismatch("angle_y", longint'($signed(want.angle_y)),
                             longint'($signed(got.angle_y)));
         end
      end
   end

   // Receiver: random stalls, a counted hold-off on request, or none at all.
   always @(negedge clock) begin
      if (stall_request > 0) begin
         hold_left = stall_request;
         stall_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (steady_flow) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= 11);
      end
   end

   // With all gains at their reset value of zero every correction stays at
   // zero, even for the largest torque errors. Left foot only, so the right
   // foot still has zero history for the derivative test.
   task automatic test_reset_state();
      send_tick(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
      send_tick(1'b0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
      send_tick(1'b0, 32'h0001_0000, 32'hFFFF_0000, 32'h8000_0000, 32'h0000_0000);
   endtask

   // Pure derivative gain: the first tick on an untouched foot sees its whole
   // error as a step, a repeated error adds nothing, larger steps hit each
   // clamp, and a full-scale swing saturates the error change.
   task automatic test_derivative_step();
      set_gains(32'd0, UNITY, 32'd0, ftoc_pkg::TIME_STEP_RESET);
      send_tick(1'b1, 32'd6553, -32'sd6553, 32'd0, 32'd0);
      send_tick(1'b1, 32'd6553, -32'sd6553, 32'd0, 32'd0);
      send_tick(1'b1, UNITY, UNITY, 32'd0, 32'd0);
      send_tick(1'b1, -UNITY, -UNITY, 32'd0, 32'd0);
      send_tick(1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
      send_tick(1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
      send_tick(1'b0, 32'd1000, 32'd2000, 32'd3000, 32'd500);
      // most negative gain flips the sign of the step
      set_gains(32'd0, 32'h8000_0000, 32'd0, ftoc_pkg::TIME_STEP_RESET);
      send_tick(1'b1, 32'd0, 32'd0, 32'd1, 32'hFFFF_FFFF);
   endtask

   // Extreme proportional and leak gains drive the rate term into its
   // saturation at the longest time step; then a moderate leaky law with
   // both feet interleaved.
   task automatic test_rate_saturation();
      set_gains(32'h7FFF_FFFF, 32'd0, 32'h8000_0000, 24'hFF_FFFF);
      send_tick(1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
      send_tick(1'b1, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_tick(1'b0, 32'd300, -32'sd300, 32'd0, 32'd0);
      set_gains(2 * UNITY, 32'd0, 4 * UNITY, ftoc_pkg::TIME_STEP_RESET);
      send_tick(1'b0, UNITY, UNITY, 32'd0, 32'd0);
      send_tick(1'b1, UNITY, -UNITY, 32'd0, 32'd0);
      send_tick(1'b0, UNITY, UNITY, 32'd0, 32'd0);
      send_tick(1'b1, 32'd0, 32'd0, 32'd0, 32'd0);
      send_tick(1'b0, 32'd0, 32'd0, 32'd0, 32'd0);
   endtask

   // Random ticks under a series of register settings: typical, random
   // moderate, both sign extremes with the time step at its ends, fully
   // random, and a negative leak that makes the correction grow.
   task automatic test_random_settings();
      set_gains(UNITY, 32'd1311, 2 * UNITY, ftoc_pkg::TIME_STEP_RESET);
      run_random_ticks(200);
      set_gains($urandom_range(0, 8 * UNITY) - 4 * UNITY,
                $urandom_range(0, 6554) - 3277,
                $urandom_range(0, 16 * UNITY) - 8 * UNITY,
                24'($urandom_range(0, 24'hFF_FFFF)));
      steady_flow = 1'b1;   // a long stretch without idling on either side
      run_random_ticks(200);
      steady_flow = 1'b0;
      set_gains(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 24'hFF_FFFF);
      run_random_ticks(150);
      set_gains(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 24'h00_0000);
      run_random_ticks(150);
      set_gains($urandom, $urandom, $urandom, 24'($urandom_range(0, 24'hFF_FFFF)));
      run_random_ticks(150);
      set_gains(UNITY / 2, 32'd0, -UNITY, 24'h00_0001);
      run_random_ticks(150);
   endtask

   // Hold the result side off for a long counted stretch while the sender
   // keeps offering ticks, so the block fills and stalls its input.
   task automatic test_backpressure();
      set_gains(UNITY, 32'd655, UNITY, ftoc_pkg::TIME_STEP_RESET);
      steady_flow = 1'b1;
      stall_request = 300;
      run_random_ticks(40);
      steady_flow = 1'b0;
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = 1'b0;
      csr_we     = 1'b0;
      csr_index  = ftoc_pkg::CSR_PROP_GAIN;
      csr_wdata  = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_derivative_step();
      test_rate_saturation();
      test_random_settings();
      test_backpressure();

      wait_drained();
      if (mismatch_count == 0) begin
         $display("foot_torque_orientation_controller: match");
      end else begin
         $display("foot_torque_orientation_controller: mismatch");
      end
      $finish;
   end

endmodule
